// File: hdl/mtfcd_pkg.sv
`timescale 1ns / 1ps
// mtfcd_pkg: sizes, derived widths and sequencer state type for the
// move-to-front color deck. No dependencies.
package mtfcd_pkg;

  // Deck geometry
  localparam int NUM_COLORS = 64;
  localparam int MAX_CARDS  = 524288;

  // Field widths fixed by the channel payloads
  localparam int COLOR_W = 6;
  localparam int POS_W   = 20;

  // Derived widths
  localparam int IDX_W = $clog2(NUM_COLORS);       // color table index
  localparam int TOP_W = $clog2(MAX_CARDS);        // 0-based card position
  localparam int CNT_W = $clog2(MAX_CARDS + 1);    // cards loaded, 0..MAX_CARDS

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,   // waiting for an input transfer
    S_START,  // decode command, handle loads, start table lookup
    S_LOOK,   // old top position of queried color is read back
    S_WALK,   // one table entry per cycle: read ahead, update behind
    S_FIX,    // queried color goes to the front
    S_OUT     // hand result to the output register
  } state_t;

endpackage

// File: hdl/mtfcd_ifs.sv
`timescale 1ns / 1ps
// mtfcd_ifs: valid/ready channel interfaces for the color deck.
// Depends on mtfcd_pkg for field widths.

// Input channel: command and color
interface mtfcd_in_if;
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic [mtfcd_pkg::COLOR_W-1:0]  color;

  modport source (output valid, output command, output color, input ready);
  modport sink   (input valid, input command, input color, output ready);
endinterface

// Result channel: position, found and full flags
interface mtfcd_out_if;
  logic                           valid;
  logic                           ready;
  logic [mtfcd_pkg::POS_W-1:0]    position;
  logic                           found;
  logic                           full_res;

  modport source (output valid, output position, output found, output full_res,
                  input ready);
  modport sink   (input valid, input position, input found, input full_res,
                  output ready);
endinterface

// File: hdl/move_to_front_color_deck.sv
`timescale 1ns / 1ps
// move_to_front_color_deck: top level, table of topmost card position per color
// with a sequenced move-to-front walk. Depends on mtfcd_pkg and mtfcd_ifs.
//
//  Channel   Dir  Payload                         Transfer when
//  in_chan   in   command[0], color[5:0]          valid && ready
//  out_chan  out  position[19:0], found, full_res valid && ready
//
//  Load, or query of an absent color: START, then OUT. Query of a present
//  color: START, LOOK, then a WALK over the whole table and FIX when it is
//  not already at the front, then OUT; the walk reads one table entry and
//  updates the one before it per cycle, using the table's read and write ports.
//  Synchronous active-low reset clears the present flags and card count; the
//  position table itself is not cleared. A stalled output holds the next
//  result in the sequencer; input ready is high only while idle.
module move_to_front_color_deck (
  input  logic                clk,
  input  logic                rst_n,
  mtfcd_in_if.sink            in_chan,
  mtfcd_out_if.source         out_chan
);
  import mtfcd_pkg::*;

  state_t state_r, state_nxt;

  // Latched input item
  logic                command_r;
  logic [COLOR_W-1:0]  color_r;

  // Deck state
  logic [NUM_COLORS-1:0] present_r;
  logic [CNT_W-1:0]      cards_loaded_r;
  logic [TOP_W-1:0]      top_mem [NUM_COLORS];
  logic [TOP_W-1:0]      rd_data_r;

  // Walk bookkeeping
  logic [TOP_W-1:0]  old_r;
  logic [IDX_W:0]    cnt_r;

  // Pending result and output register
  logic [POS_W-1:0]  res_pos_r;
  logic              res_found_r;
  logic              res_full_r;
  logic              out_valid_r;
  logic [POS_W-1:0]  out_pos_r;
  logic              out_found_r;
  logic              out_full_r;

  // Decoded helpers
  logic [IDX_W-1:0]  col_idx;
  logic              col_in_range;
  logic              col_present;
  logic              deck_full;
  logic [IDX_W:0]    prev_cnt;
  logic [IDX_W-1:0]  prev_idx;
  logic              walk_last;
  logic              walk_bump;
  logic              out_free;
  logic              in_xfer;

  // Memory port controls
  logic              in_ready;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [TOP_W-1:0]  wr_data;

  assign col_idx      = IDX_W'({{IDX_W{1'b0}}, color_r});
  assign col_in_range = {{(32-COLOR_W){1'b0}}, color_r} < 32'(NUM_COLORS);
  assign col_present  = col_in_range && present_r[col_idx];
  assign deck_full    = cards_loaded_r >= CNT_W'(MAX_CARDS);
  assign prev_cnt     = cnt_r - 1'b1;
  assign prev_idx     = prev_cnt[IDX_W-1:0];
  assign walk_last    = cnt_r == (IDX_W+1)'(NUM_COLORS);
  // Entry read last cycle moves down if it sat above the queried card
  assign walk_bump    = (cnt_r != '0) && (prev_idx != col_idx) &&
                        present_r[prev_idx] && (rd_data_r < old_r);
  assign out_free     = !out_valid_r || out_chan.ready;
  assign in_xfer      = in_chan.valid && in_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_chan.valid) state_nxt = S_START;
      S_START: state_nxt = (command_r && col_present) ? S_LOOK : S_OUT;
      S_LOOK:  state_nxt = (rd_data_r == '0) ? S_OUT : S_WALK;
      S_WALK:  if (walk_last) state_nxt = S_FIX;
      S_FIX:   state_nxt = S_OUT;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and table port
  always_comb begin
    in_ready = 1'b0;
    rd_addr  = col_idx;
    wr_en    = 1'b0;
    wr_addr  = col_idx;
    wr_data  = '0;
    unique case (state_r)
      S_IDLE:  in_ready = 1'b1;
      S_START: begin
        // first card of a color records its position
        wr_en   = !command_r && !deck_full && col_in_range && !present_r[col_idx];
        wr_data = cards_loaded_r[TOP_W-1:0];
      end
      S_LOOK:  ;
      S_WALK: begin
        rd_addr = cnt_r[IDX_W-1:0];
        wr_en   = walk_bump;
        wr_addr = prev_idx;
        wr_data = rd_data_r + 1'b1;
      end
      S_FIX:   wr_en = 1'b1;
      S_OUT:   ;
      default: ;
    endcase
  end

  // Position table: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      top_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= top_mem[rd_addr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      present_r      <= '0;
      cards_loaded_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_START && !command_r && !deck_full) begin
        cards_loaded_r <= cards_loaded_r + 1'b1;
        if (col_in_range) begin
          present_r[col_idx] <= 1'b1;
        end
      end
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload and walk registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      command_r <= in_chan.command;
      color_r   <= in_chan.color;
    end
    case (state_r)
      S_START: begin
        res_pos_r   <= '0;
        res_found_r <= 1'b0;
        res_full_r  <= !command_r && deck_full;
      end
      S_LOOK: begin
        old_r       <= rd_data_r;
        cnt_r       <= '0;
        res_found_r <= 1'b1;
        res_pos_r   <= POS_W'({1'b0, rd_data_r} + 1'b1);
      end
      S_WALK:  cnt_r <= cnt_r + 1'b1;
      S_OUT: begin
        if (out_free) begin
          out_pos_r   <= res_pos_r;
          out_found_r <= res_found_r;
          out_full_r  <= res_full_r;
        end
      end
      default: ;
    endcase
  end

  assign in_chan.ready     = in_ready;
  assign out_chan.valid    = out_valid_r;
  assign out_chan.position = out_pos_r;
  assign out_chan.found    = out_found_r;
  assign out_chan.full_res = out_full_r;

endmodule

// File: hdl/mtfcd_checker.sv
`timescale 1ns / 1ps
// mtfcd_checker: port-level assertions for move_to_front_color_deck, bound to
// the top level below. Depends on mtfcd_pkg for field widths.
module mtfcd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [mtfcd_pkg::POS_W-1:0]   out_position,
  input logic                          out_found,
  input logic                          out_full_res
);
  import mtfcd_pkg::*;

  // Output register is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_position) &&
    $stable(out_found) && $stable(out_full_res))
    else $error("stalled result changed");

  // Loads and absent queries report position zero; hits report a nonzero one
  a_pos_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_found == (out_position != '0)))
    else $error("position does not agree with found");

  // A result never flags both a query hit and a dropped load
  a_found_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_found && out_full_res))
    else $error("found and full both set");

  // Item transfer is never taken in the cycle after one was accepted
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transfer");

endmodule

bind move_to_front_color_deck mtfcd_checker u_mtfcd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_position (out_chan.position),
  .out_found    (out_chan.found),
  .out_full_res (out_chan.full_res)
);

// File: verif/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for move_to_front_color_deck. Drives load and
// query transfers with random gaps and stalls and checks each result against a
// table model or a typed-in value. Depends on mtfcd_pkg, mtfcd_ifs and the DUT.
module testbench;
  import mtfcd_pkg::*;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } deck_cmd_t;

  // How a script row is checked: by the local model or by a typed-in result
  typedef enum logic {
    CHK_MODEL = 1'b0,
    CHK_TYPED = 1'b1
  } chk_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             found;
    logic             full_res;
  } deck_result_t;

  typedef struct packed {
    deck_cmd_t          cmd;
    logic [COLOR_W-1:0] color;
    chk_t               chk;
    deck_result_t       want;
  } deck_row_t;

  localparam deck_result_t R_ZERO  = '0;
  localparam deck_result_t R_FRONT = deck_result_t'({20'd1, 1'b1, 1'b0});

  // Color kept out of random loads; the tail rows load it first
  localparam logic [COLOR_W-1:0] LATE_COLOR = 6'd63;

  localparam int OPEN_FIRST = 0;
  localparam int OPEN_LAST  = 22;
  localparam int TAIL_FIRST = 23;
  localparam int TAIL_LAST  = 31;

  // Opening rows start from an empty deck; tail rows follow the random traffic
  deck_row_t script_rows [0:31] = '{
    '{CMD_QUERY, 6'd0,  CHK_TYPED, R_ZERO},   // absent on empty deck
    '{CMD_QUERY, 6'd63, CHK_TYPED, R_ZERO},
    '{CMD_LOAD,  6'd0,  CHK_TYPED, R_ZERO},
    '{CMD_LOAD,  6'd0,  CHK_TYPED, R_ZERO},   // duplicate color, not recorded
    '{CMD_LOAD,  6'd42, CHK_TYPED, R_ZERO},
    '{CMD_LOAD,  6'd21, CHK_TYPED, R_ZERO},
    '{CMD_QUERY, 6'd0,  CHK_TYPED, R_FRONT},  // already at the front
    '{CMD_QUERY, 6'd42, CHK_MODEL, R_ZERO},
    '{CMD_QUERY, 6'd42, CHK_TYPED, R_FRONT},
    '{CMD_QUERY, 6'd21, CHK_MODEL, R_ZERO},
    '{CMD_QUERY, 6'd0,  CHK_MODEL, R_ZERO},
    '{CMD_LOAD,  6'd1,  CHK_TYPED, R_ZERO},
    '{CMD_LOAD,  6'd62, CHK_TYPED, R_ZERO},
    '{CMD_QUERY, 6'd62, CHK_MODEL, R_ZERO},
    '{CMD_QUERY, 6'd1,  CHK_MODEL, R_ZERO},
    '{CMD_QUERY, 6'd63, CHK_TYPED, R_ZERO},
    '{CMD_QUERY, 6'd56, CHK_TYPED, R_ZERO},
    '{CMD_LOAD,  6'd56, CHK_TYPED, R_ZERO},   // load after queries
    '{CMD_QUERY, 6'd56, CHK_MODEL, R_ZERO},
    '{CMD_QUERY, 6'd56, CHK_TYPED, R_FRONT},
    '{CMD_QUERY, 6'd7,  CHK_TYPED, R_ZERO},
    '{CMD_LOAD,  6'd7,  CHK_TYPED, R_ZERO},
    '{CMD_QUERY, 6'd0,  CHK_MODEL, R_ZERO},
    // tail: late color lands below every card, moves to the front, more loads
    '{CMD_LOAD,  6'd63, CHK_TYPED, R_ZERO},
    '{CMD_QUERY, 6'd63, CHK_MODEL, R_ZERO},
    '{CMD_QUERY, 6'd63, CHK_TYPED, R_FRONT},
    '{CMD_LOAD,  6'd5,  CHK_TYPED, R_ZERO},
    '{CMD_LOAD,  6'd63, CHK_TYPED, R_ZERO},
    '{CMD_QUERY, 6'd0,  CHK_MODEL, R_ZERO},
    '{CMD_QUERY, 6'd42, CHK_MODEL, R_ZERO},
    '{CMD_LOAD,  6'd0,  CHK_TYPED, R_ZERO},
    '{CMD_QUERY, 6'd63, CHK_MODEL, R_ZERO}
  };

  logic clk = 1'b0;
  logic rst_n;

  mtfcd_in_if  deck_in ();
  mtfcd_out_if deck_out ();

  move_to_front_color_deck dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (deck_in),
    .out_chan (deck_out)
  );

  always #4 clk = ~clk;

  // Local copy of the color table
  logic               color_seen [NUM_COLORS];
  logic [TOP_W-1:0]   color_top  [NUM_COLORS];
  logic [CNT_W-1:0]   cards_held;

  deck_result_t       pending_q [$];
  int                 fault_cnt = 0;
  bit                 tx_gaps_on = 1'b1;
  bit                 rx_stall_on = 1'b1;

  // Apply one command to the local table and return the result it gives
  function automatic deck_result_t deck_apply(deck_cmd_t cmd, logic [COLOR_W-1:0] color);
    deck_result_t     r;
    logic [TOP_W-1:0] old;
    r = '0;
    if (cmd == CMD_LOAD) begin
      if (cards_held >= CNT_W'(MAX_CARDS)) begin
        r.full_res = 1'b1;
      end else begin
        if (!color_seen[color]) begin
          color_seen[color] = 1'b1;
          color_top[color]  = cards_held[TOP_W-1:0];
        end
        cards_held = cards_held + 1'b1;
      end
    end else if (color_seen[color]) begin
      old        = color_top[color];
      r.found    = 1'b1;
      r.position = POS_W'(old) + 1'b1;
      if (old != '0) begin
        for (int k = 0; k < NUM_COLORS; k++) begin
          if (k != color && color_seen[k] && color_top[k] < old)
            color_top[k] = color_top[k] + 1'b1;
        end
        color_top[color] = '0;
      end
    end
    return r;
  endfunction

  // One input transfer; valid stays high afterwards until a later gap or a drain lowers it
  task automatic send_item(deck_cmd_t cmd, logic [COLOR_W-1:0] color, chk_t chk,
                           deck_result_t want);
    int           gap;
    deck_result_t got;
    gap = tx_gaps_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      deck_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    deck_in.valid   <= 1'b1;
    deck_in.command <= cmd;
    deck_in.color   <= color;
    @(posedge clk);
    while (!deck_in.ready) @(posedge clk);
    got = deck_apply(cmd, color);
    pending_q.push_back((chk == CHK_TYPED) ? want : got);
  endtask

  task automatic walk_rows(int first, int last);
    for (int i = first; i <= last; i++)
      send_item(script_rows[i].cmd, script_rows[i].color, script_rows[i].chk,
                script_rows[i].want);
  endtask

  // Hold off the sender until every outstanding result has come back
  task automatic drain_results();
    deck_in.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    int                 pick;
    int                 n_seen;
    logic [COLOR_W-1:0] seen_list [NUM_COLORS];
    logic [COLOR_W-1:0] col;
    deck_cmd_t          cmd;

    for (int k = 0; k < NUM_COLORS; k++) begin
      color_seen[k] = 1'b0;
      color_top[k]  = '0;
    end
    cards_held = '0;

    rst_n           <= 1'b0;
    deck_in.valid   <= 1'b0;
    deck_in.command <= CMD_LOAD;
    deck_in.color   <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    walk_rows(OPEN_FIRST, OPEN_LAST);

    // Random traffic: mostly loads and queries of present colors, some noise
    for (int chunk = 0; chunk < 16; chunk++) begin
      tx_gaps_on  = ($urandom_range(0, 3) != 0);
      rx_stall_on = ($urandom_range(0, 3) != 0);
      if (chunk == 8)
        drain_results();
      for (int i = 0; i < 100; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          cmd = CMD_LOAD;
          col = COLOR_W'($urandom_range(0, int'(LATE_COLOR) - 1));
        end else if (pick < 90) begin
          cmd    = CMD_QUERY;
          n_seen = 0;
          for (int k = 0; k < NUM_COLORS; k++) begin
            if (color_seen[k]) begin
              seen_list[n_seen] = COLOR_W'(k);
              n_seen++;
            end
          end
          col = (n_seen > 0) ? seen_list[$urandom_range(0, n_seen - 1)]
                             : COLOR_W'($urandom_range(0, 63));
        end else begin
          cmd = CMD_QUERY;
          col = COLOR_W'($urandom_range(0, 63));
        end
        send_item(cmd, col, CHK_MODEL, R_ZERO);
      end
    end

    tx_gaps_on  = 1'b1;
    rx_stall_on = 1'b1;
    walk_rows(TAIL_FIRST, TAIL_LAST);
    deck_in.valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fault_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Result side: random stalls, compare each transfer with the oldest expectation
  initial begin
    int           stall;
    deck_result_t exp_r;
    deck_out.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = rx_stall_on ? $urandom_range(0, 6) : 0;
      if (stall > 0) begin
        deck_out.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      deck_out.ready <= 1'b1;
      @(posedge clk);
      while (!deck_out.valid) @(posedge clk);
      if (pending_q.size() == 0) begin
        fault_cnt++;
        if (fault_cnt <= 10)
          $display("unexpected result: pos=%0d found=%0d full=%0d",
                   deck_out.position, deck_out.found, deck_out.full_res);
      end else begin
        exp_r = pending_q.pop_front();
        if (deck_out.position !== exp_r.position || deck_out.found !== exp_r.found ||
            deck_out.full_res !== exp_r.full_res) begin
          fault_cnt++;
          if (fault_cnt <= 10)
            $display({"mismatch: expected pos=%0d found=%0d full=%0d, ",
                      "got pos=%0d found=%0d full=%0d"},
                     exp_r.position, exp_r.found, exp_r.full_res,
                     deck_out.position, deck_out.found, deck_out.full_res);
        end
      end
    end
  end

  // Watchdog
  initial begin
    #300_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: filelist.f
hdl/mtfcd_pkg.sv
hdl/mtfcd_ifs.sv
hdl/move_to_front_color_deck.sv
hdl/mtfcd_checker.sv
verif/testbench.sv
